FILE: design/assert_macros.svh
// Assertion macros used by two_species_cell_automaton.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of clk_i while rst_ni is high.
`define TSCA_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

// Checked on every rising edge of clk_i, during reset as well.
`define TSCA_ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk_i) (prop)) \
    else $error("assertion failed");

`endif

FILE: design/tsca_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tsca_pkg;

  localparam int GRID_SIDE = 64;
  localparam int CELLS     = GRID_SIDE * GRID_SIDE;
  localparam int ADDR_W    = $clog2(CELLS);
  localparam int CTR       = GRID_SIDE + 1;
  localparam int CHAIN_LEN = 2 * GRID_SIDE + 3;
  localparam int LAST_FEED = CELLS - 1 + CTR;
  localparam int FEED_W    = $clog2(LAST_FEED + 2);
  localparam int XY_W      = $clog2(GRID_SIDE);
  localparam int COUNT_W   = 13;

  localparam logic [1:0] SP_EMPTY = 2'd0;
  localparam logic [1:0] SP_ONE   = 2'd1;
  localparam logic [1:0] SP_TWO   = 2'd2;

  typedef enum logic [1:0] {
    MODE_PLACE  = 2'd0,
    MODE_GEN    = 2'd1,
    MODE_READ   = 2'd2,
    MODE_REPORT = 2'd3
  } mode_e;

  typedef struct packed {
    mode_e      mode;
    logic [5:0] col;
    logic [5:0] row;
    logic [1:0] species;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         cell_value;
    logic [COUNT_W-1:0] empty_count;
    logic [COUNT_W-1:0] first_count;
    logic [COUNT_W-1:0] second_count;
  } out_item_t;

  typedef struct packed {
    logic shift;
    logic at_top;
    logic at_bottom;
    logic at_left;
    logic at_right;
  } win_ctrl_t;

  function automatic logic [1:0] next_cell(logic [1:0] own, logic [3:0] n1,
                                           logic [3:0] n2);
    logic [3:0] big;
    logic [1:0] kind;
    logic [1:0] res;
    big  = (n1 > n2) ? n1 : n2;
    kind = (n1 > n2) ? SP_ONE : SP_TWO;
    res  = own;
    if (n1 == n2) begin
      res = SP_EMPTY;
    end else if (big >= 4'd3 && big <= 4'd6) begin
      res = kind;
    end else if (big == 4'd7 || big == 4'd8) begin
      res = SP_EMPTY;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

FILE: design/tsca_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module tsca_cell
  import tsca_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       shift_i,
  input  wire logic [1:0] d_i,
  output logic      [1:0] q_o
);

  logic [1:0] val_q;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      val_q <= d_i;
    end
  end

  assign q_o = val_q;

endmodule

`default_nettype wire

FILE: design/tsca_chain.sv
`timescale 1ns / 1ps
`default_nettype none

module tsca_chain
  import tsca_pkg::*;
(
  input  wire logic       clk_i,
  input  wire win_ctrl_t  ctrl_i,
  input  wire logic [1:0] data_i,
  output logic      [1:0] new_o
);

  logic [1:0] tap [CHAIN_LEN];
  logic [8:0] is1;
  logic [8:0] is2;
  logic [8:0] keep;
  logic [1:0] own;
  logic [3:0] n1;
  logic [3:0] n2;

  for (genvar k = 0; k < CHAIN_LEN; k++) begin : g_cell
    if (k == 0) begin : g_head
      tsca_cell u_cell (
        .clk_i  (clk_i),
        .shift_i(ctrl_i.shift),
        .d_i    (data_i),
        .q_o    (tap[k])
      );
    end else begin : g_body
      tsca_cell u_cell (
        .clk_i  (clk_i),
        .shift_i(ctrl_i.shift),
        .d_i    (tap[k-1]),
        .q_o    (tap[k])
      );
    end
  end

  assign own = tap[CTR];

  for (genvar gy = 0; gy < 3; gy++) begin : g_row
    for (genvar gx = 0; gx < 3; gx++) begin : g_col
      localparam int TAP = CTR - (gy - 1) * GRID_SIDE - (gx - 1);
      localparam int K   = gy * 3 + gx;
      assign keep[K] = !((gy == 0) && ctrl_i.at_top) && !((gy == 2) && ctrl_i.at_bottom) &&
                       !((gx == 0) && ctrl_i.at_left) && !((gx == 2) && ctrl_i.at_right);
      assign is1[K] = keep[K] && (tap[TAP] != own) && (tap[TAP] == SP_ONE);
      assign is2[K] = keep[K] && (tap[TAP] != own) && (tap[TAP] == SP_TWO);
    end
  end

  always_comb begin
    n1 = '0;
    n2 = '0;
    for (int i = 0; i < 9; i++) begin
      n1 = n1 + 4'(is1[i]);
      n2 = n2 + 4'(is2[i]);
    end
  end

  assign new_o = next_cell(own, n1, n2);

endmodule

`default_nettype wire

FILE: design/two_species_cell_automaton.sv
// Every accepted item, whether place, read, report or generation, ends with a done_o strobe.
// One item is in work at a time; the single read port of the grid memory sets the sweep
// to one cell per cycle for a generation or a report.
// After reset the grid memory is cleared one cell per cycle, all 4096 cells, with busy high.
// done_o is high for one cycle only, res_o until the next result; the receiver cannot stall.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module two_species_cell_automaton
  import tsca_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      start,
  output logic           busy,
  input  wire in_item_t  cmd_i,
  output logic           done_o,
  output out_item_t      res_o
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_GEN,
    S_COUNT
  } state_e;

  state_e              state_q;
  logic [FEED_W-1:0]   feed_cnt_q;
  logic                a_vld_q;
  logic [FEED_W-1:0]   a_idx_q;
  logic                a_pad_q;
  logic                b_vld_q;
  logic [ADDR_W-1:0]   wr_addr_q;
  logic [XY_W-1:0]     cx_q;
  logic [XY_W-1:0]     cy_q;
  logic                on_grid_q;
  logic [COUNT_W-1:0]  c0_q;
  logic [COUNT_W-1:0]  c1_q;
  logic [COUNT_W-1:0]  c2_q;
  logic [COUNT_W-1:0]  c0_d;
  logic [COUNT_W-1:0]  c1_d;
  logic [COUNT_W-1:0]  c2_d;
  logic                done_q;
  out_item_t           res_q;

  logic [1:0]          mem [CELLS];
  logic [1:0]          mem_rd_q;
  logic                mem_we;
  logic [ADDR_W-1:0]   mem_waddr;
  logic [ADDR_W-1:0]   mem_raddr;
  logic [1:0]          mem_wdata;

  logic                accept;
  logic                on_grid;
  logic [ADDR_W-1:0]   cmd_idx;
  win_ctrl_t           win_ctrl;
  logic [1:0]          chain_in;
  logic [1:0]          new_val;

  assign busy    = (state_q != S_IDLE);
  assign accept  = start && !busy;
  assign on_grid = (32'(cmd_i.col) < GRID_SIDE) && (32'(cmd_i.row) < GRID_SIDE);
  assign cmd_idx = ADDR_W'(32'(cmd_i.row) * GRID_SIDE + 32'(cmd_i.col));

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = feed_cnt_q[ADDR_W-1:0];
    mem_wdata = SP_EMPTY;
    mem_raddr = feed_cnt_q[ADDR_W-1:0];
    unique case (state_q)
      S_CLEAR: begin
        mem_we = 1'b1;
      end
      S_IDLE: begin
        mem_raddr = cmd_idx;
        mem_waddr = cmd_idx;
        mem_wdata = cmd_i.species;
        mem_we    = accept && (cmd_i.mode == MODE_PLACE) && on_grid &&
                    ((cmd_i.species == SP_ONE) || (cmd_i.species == SP_TWO));
      end
      S_GEN: begin
        mem_we    = b_vld_q;
        mem_waddr = wr_addr_q;
        mem_wdata = new_val;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_rd_q <= mem[mem_raddr];
  end

  assign chain_in           = a_pad_q ? SP_EMPTY : mem_rd_q;
  assign win_ctrl.shift     = a_vld_q && (state_q == S_GEN);
  assign win_ctrl.at_top    = (cy_q == '0);
  assign win_ctrl.at_bottom = (cy_q == XY_W'(GRID_SIDE - 1));
  assign win_ctrl.at_left   = (cx_q == '0);
  assign win_ctrl.at_right  = (cx_q == XY_W'(GRID_SIDE - 1));

  tsca_chain u_chain (
    .clk_i (clk_i),
    .ctrl_i(win_ctrl),
    .data_i(chain_in),
    .new_o (new_val)
  );

  assign c0_d = c0_q + COUNT_W'(mem_rd_q == SP_EMPTY);
  assign c1_d = c1_q + COUNT_W'(mem_rd_q == SP_ONE);
  assign c2_d = c2_q + COUNT_W'(mem_rd_q == SP_TWO);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      feed_cnt_q <= '0;
      a_vld_q    <= 1'b0;
      a_idx_q    <= '0;
      a_pad_q    <= 1'b0;
      b_vld_q    <= 1'b0;
      wr_addr_q  <= '0;
      cx_q       <= '0;
      cy_q       <= '0;
      on_grid_q  <= 1'b0;
      c0_q       <= '0;
      c1_q       <= '0;
      c2_q       <= '0;
      done_q     <= 1'b0;
      res_q      <= '0;
    end else begin
      done_q  <= 1'b0;
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      unique case (state_q)
        S_CLEAR: begin
          feed_cnt_q <= feed_cnt_q + 1'b1;
          if (feed_cnt_q == FEED_W'(CELLS - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            feed_cnt_q <= '0;
            wr_addr_q  <= '0;
            cx_q       <= '0;
            cy_q       <= '0;
            c0_q       <= '0;
            c1_q       <= '0;
            c2_q       <= '0;
            on_grid_q  <= on_grid;
            unique case (cmd_i.mode)
              MODE_PLACE: begin
                done_q <= 1'b1;
                res_q  <= '0;
              end
              MODE_GEN:    state_q <= S_GEN;
              MODE_READ:   state_q <= S_READ;
              MODE_REPORT: state_q <= S_COUNT;
              default:     state_q <= S_IDLE;
            endcase
          end
        end
        S_READ: begin
          done_q             <= 1'b1;
          res_q.cell_value   <= on_grid_q ? mem_rd_q : SP_EMPTY;
          res_q.empty_count  <= '0;
          res_q.first_count  <= '0;
          res_q.second_count <= '0;
          state_q            <= S_IDLE;
        end
        S_GEN: begin
          if (feed_cnt_q <= FEED_W'(LAST_FEED)) begin
            feed_cnt_q <= feed_cnt_q + 1'b1;
            a_vld_q    <= 1'b1;
            a_idx_q    <= feed_cnt_q;
            a_pad_q    <= (feed_cnt_q >= FEED_W'(CELLS));
          end
          b_vld_q <= a_vld_q && (a_idx_q >= FEED_W'(CTR));
          if (b_vld_q) begin
            wr_addr_q <= wr_addr_q + 1'b1;
            if (cx_q == XY_W'(GRID_SIDE - 1)) begin
              cx_q <= '0;
              cy_q <= cy_q + 1'b1;
            end else begin
              cx_q <= cx_q + 1'b1;
            end
            if (wr_addr_q == ADDR_W'(CELLS - 1)) begin
              done_q  <= 1'b1;
              res_q   <= '0;
              state_q <= S_IDLE;
            end
          end
        end
        S_COUNT: begin
          if (feed_cnt_q < FEED_W'(CELLS)) begin
            feed_cnt_q <= feed_cnt_q + 1'b1;
            a_vld_q    <= 1'b1;
            a_idx_q    <= feed_cnt_q;
            a_pad_q    <= 1'b0;
          end
          if (a_vld_q) begin
            c0_q <= c0_d;
            c1_q <= c1_d;
            c2_q <= c2_d;
            if (a_idx_q == FEED_W'(CELLS - 1)) begin
              done_q             <= 1'b1;
              res_q.cell_value   <= SP_EMPTY;
              res_q.empty_count  <= c0_d;
              res_q.first_count  <= c1_d;
              res_q.second_count <= c2_d;
              state_q            <= S_IDLE;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

  `TSCA_ASSERT(gen_no_rw_clash, (state_q == S_GEN && mem_we) |-> (mem_waddr != mem_raddr))
  `TSCA_ASSERT(no_result_in_clear, (state_q == S_CLEAR) |-> !done_o)
  `TSCA_ASSERT(window_follows_feed, b_vld_q |-> $past(a_vld_q))
  `TSCA_ASSERT(gen_goes_busy, (accept && cmd_i.mode == MODE_GEN) |=> busy)

endmodule

`default_nettype wire
